// File: design/tsc_pkg.sv
// shared types and constants for the taylor sine/cosine core
// fixed-point widths, saturation bounds and the reciprocal table
// no dependencies
package tsc_pkg;

   localparam int FRAC_BITS = 28;

   localparam int ANGLE_W   = 31;
   localparam int REF_W     = 30;
   localparam int TOL_W     = 29;
   localparam int OUT_W     = 31;
   localparam int TERMS_W   = 5;
   localparam int MAG_W     = 34;
   localparam int TERM_W    = MAG_W + 1;
   localparam int SUM_W     = MAG_W + 2;
   localparam int DIFF_W    = SUM_W + 1;
   localparam int IDX_W     = 6;
   localparam int PROD_W    = 2 * MAG_W;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [REF_W-1:0]   ref_type;
   typedef logic        [TOL_W-1:0]   tol_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef logic        [TERMS_W-1:0] terms_type;
   typedef logic        [MAG_W-1:0]   mag_type;
   typedef logic signed [TERM_W-1:0]  term_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic        [IDX_W-1:0]   idx_type;

   localparam logic SEL_SINE   = 1'b0;
   localparam logic SEL_COSINE = 1'b1;

   localparam tol_type TOL_RESET = TOL_W'(256);

   localparam longint unsigned FRAC_ONE  = 64'd1 << FRAC_BITS;
   localparam longint unsigned FRAC_HALF = FRAC_ONE >> 1;

   localparam sum_type OUT_HI = SUM_W'((longint'(1) << (OUT_W - 1)) - 1);
   localparam sum_type OUT_LO = SUM_W'(-(longint'(1) << (OUT_W - 1)));

   // round(2^F / ((i+1)(i+2))) for i = 0 .. 63
   localparam int RECIP_DEPTH = 64;
   localparam longint unsigned RECIP_TABLE [RECIP_DEPTH] = '{
      (FRAC_ONE + 1) / 2,       (FRAC_ONE + 3) / 6,       (FRAC_ONE + 6) / 12,
      (FRAC_ONE + 10) / 20,     (FRAC_ONE + 15) / 30,     (FRAC_ONE + 21) / 42,
      (FRAC_ONE + 28) / 56,     (FRAC_ONE + 36) / 72,     (FRAC_ONE + 45) / 90,
      (FRAC_ONE + 55) / 110,    (FRAC_ONE + 66) / 132,    (FRAC_ONE + 78) / 156,
      (FRAC_ONE + 91) / 182,    (FRAC_ONE + 105) / 210,   (FRAC_ONE + 120) / 240,
      (FRAC_ONE + 136) / 272,   (FRAC_ONE + 153) / 306,   (FRAC_ONE + 171) / 342,
      (FRAC_ONE + 190) / 380,   (FRAC_ONE + 210) / 420,   (FRAC_ONE + 231) / 462,
      (FRAC_ONE + 253) / 506,   (FRAC_ONE + 276) / 552,   (FRAC_ONE + 300) / 600,
      (FRAC_ONE + 325) / 650,   (FRAC_ONE + 351) / 702,   (FRAC_ONE + 378) / 756,
      (FRAC_ONE + 406) / 812,   (FRAC_ONE + 435) / 870,   (FRAC_ONE + 465) / 930,
      (FRAC_ONE + 496) / 992,   (FRAC_ONE + 528) / 1056,  (FRAC_ONE + 561) / 1122,
      (FRAC_ONE + 595) / 1190,  (FRAC_ONE + 630) / 1260,  (FRAC_ONE + 666) / 1332,
      (FRAC_ONE + 703) / 1406,  (FRAC_ONE + 741) / 1482,  (FRAC_ONE + 780) / 1560,
      (FRAC_ONE + 820) / 1640,  (FRAC_ONE + 861) / 1722,  (FRAC_ONE + 903) / 1806,
      (FRAC_ONE + 946) / 1892,  (FRAC_ONE + 990) / 1980,  (FRAC_ONE + 1035) / 2070,
      (FRAC_ONE + 1081) / 2162, (FRAC_ONE + 1128) / 2256, (FRAC_ONE + 1176) / 2352,
      (FRAC_ONE + 1225) / 2450, (FRAC_ONE + 1275) / 2550, (FRAC_ONE + 1326) / 2652,
      (FRAC_ONE + 1378) / 2756, (FRAC_ONE + 1431) / 2862, (FRAC_ONE + 1485) / 2970,
      (FRAC_ONE + 1540) / 3080, (FRAC_ONE + 1596) / 3192, (FRAC_ONE + 1653) / 3306,
      (FRAC_ONE + 1711) / 3422, (FRAC_ONE + 1770) / 3540, (FRAC_ONE + 1830) / 3660,
      (FRAC_ONE + 1891) / 3782, (FRAC_ONE + 1953) / 3906, (FRAC_ONE + 2016) / 4032,
      (FRAC_ONE + 2080) / 4160
   };

endpackage

// File: design/tsc_channels.sv
// request and response channel interfaces for the taylor sine/cosine core
// depends on tsc_pkg
interface tsc_req_if;
   import tsc_pkg::*;
   logic      valid;
   logic      ready;
   logic      req_type;
   angle_type angle;
   ref_type   reference;
   modport source (output valid, req_type, angle, reference, input ready);
   modport sink (input valid, req_type, angle, reference, output ready);
endinterface

interface tsc_rsp_if;
   import tsc_pkg::*;
   logic      valid;
   logic      ready;
   out_type   approx_value;
   terms_type terms_used;
   logic      limit_hit;
   modport source (output valid, approx_value, terms_used, limit_hit, input ready);
   modport sink (input valid, approx_value, terms_used, limit_hit, output ready);
endinterface

// File: design/tsc_qmul.sv
// shared fixed-point magnitude multiplier: round(a * b / 2^F), half up on magnitudes
// depends on tsc_pkg
module tsc_qmul (
   input  tsc_pkg::mag_type a,
   input  tsc_pkg::mag_type b,
   output tsc_pkg::mag_type prod_q
);
   import tsc_pkg::*;

   logic [PROD_W-1:0] full;
   logic [PROD_W-1:0] rounded;

   assign full    = PROD_W'(a) * PROD_W'(b);
   assign rounded = full + PROD_W'(FRAC_HALF);
   assign prod_q  = rounded[FRAC_BITS +: MAG_W];

endmodule

// File: design/taylor_sin_cos_until_tolerance_core.sv
// taylor sine/cosine core: one transaction summed term by term on a shared multiplier
// a new request is accepted only in idle, once the previous transaction has finished;
// each series term runs an add / check / term-update step on the single multiplier, and
// a finishing check step stalls while the previous response is still unaccepted
// synchronous active-high reset clears control state and sets tolerance to 256
// depends on tsc_pkg, tsc_channels, tsc_qmul
module taylor_sin_cos_until_tolerance_core #(
   parameter int MAX_TERMS = 16
) (
   input  logic             clock,
   input  logic             reset,
   tsc_req_if.sink          req_chan,
   tsc_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  tsc_pkg::tol_type csr_wr_data
);
   import tsc_pkg::*;

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_TRM  = 3'd4;

   logic [2:0]       state_ff, state_in;
   tol_type          tol_ff;
   angle_type        angle_ff, angle_in;
   ref_type          ref_ff, ref_in;
   mag_type          x2_ff, x2_in;
   mag_type          factor_ff, factor_in;
   term_type         term_ff, term_in;
   sum_type          sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   idx_type          idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   out_type          approx_ff, approx_in;
   terms_type        terms_ff, terms_in;
   logic             limit_ff, limit_in;

   logic [ANGLE_W-1:0] x_mag;
   logic [TERM_W-1:0]  term_mag;
   diff_type           diff;
   logic [DIFF_W-1:0]  diff_mag;
   logic               within_tol;
   logic               at_limit;
   logic               rsp_free;
   mag_type            mul_a, mul_b, mul_q;
   sum_type            sum_sat;

   assign x_mag      = angle_ff[ANGLE_W-1] ? (~angle_ff + 1'b1) : angle_ff;
   assign term_mag   = term_ff[TERM_W-1] ? (~term_ff + 1'b1) : term_ff;
   assign diff       = DIFF_W'(ref_ff) - DIFF_W'(sum_ff);
   assign diff_mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
   assign within_tol = diff_mag <= DIFF_W'(tol_ff);
   assign at_limit   = cnt_ff >= CNT_W'(MAX_TERMS);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign sum_sat    = (sum_ff > OUT_HI) ? OUT_HI : ((sum_ff < OUT_LO) ? OUT_LO : sum_ff);

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQ: begin
            mul_a = MAG_W'(x_mag);
            mul_b = MAG_W'(x_mag);
         end
         ST_CHK: begin
            mul_a = x2_ff;
            mul_b = MAG_W'(RECIP_TABLE[idx_ff]);
         end
         default: begin
            mul_a = MAG_W'(term_mag);
            mul_b = factor_ff;
         end
      endcase
   end

   tsc_qmul u_qmul (
      .a      (mul_a),
      .b      (mul_b),
      .prod_q (mul_q)
   );

   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      ref_in       = ref_ff;
      x2_in        = x2_ff;
      factor_in    = factor_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      approx_in    = approx_ff;
      terms_in     = terms_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               angle_in = req_chan.angle;
               ref_in   = req_chan.reference;
               sum_in   = '0;
               cnt_in   = '0;
               if (req_chan.req_type == SEL_COSINE) begin
                  term_in = TERM_W'(FRAC_ONE);
                  idx_in  = IDX_W'(0);
               end else begin
                  term_in = TERM_W'(req_chan.angle);
                  idx_in  = IDX_W'(1);
               end
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            x2_in    = mul_q;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sum_ff + SUM_W'(term_ff);
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            factor_in = mul_q;
            if (within_tol || at_limit) begin
               if (rsp_free) begin
                  approx_in    = OUT_W'(sum_sat);
                  terms_in     = TERMS_W'(cnt_ff);
                  limit_in     = !within_tol;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_TRM;
            end
         end
         ST_TRM: begin
            // next term takes the opposite sign of the current one
            term_in  = term_ff[TERM_W-1] ? TERM_W'(mul_q) : -TERM_W'(mul_q);
            idx_in   = idx_ff + IDX_W'(2);
            state_in = ST_ADD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      angle_ff  <= angle_in;
      ref_ff    <= ref_in;
      x2_ff     <= x2_in;
      factor_ff <= factor_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      approx_ff <= approx_in;
      terms_ff  <= terms_in;
      limit_ff  <= limit_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.approx_value = approx_ff;
   assign rsp_chan.terms_used   = terms_ff;
   assign rsp_chan.limit_hit    = limit_ff;

endmodule
